FILE: rtl/kbp_pkg.sv
// ----------------------------------------------------------------------------
// kbp_pkg
// Shared types and constants for the keyboard port and loopback fifo core.
// ----------------------------------------------------------------------------
package kbp_pkg;

    // access kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_KEY   = 2'd2;

    // forward targets
    localparam logic [1:0] TGT_NONE   = 2'd0;
    localparam logic [1:0] TGT_SERIAL = 2'd1;
    localparam logic [1:0] TGT_TIMER  = 2'd2;

    // offset groups, address bits 4..2
    localparam logic [2:0] GRP_KEY    = 3'b000;
    localparam logic [2:0] GRP_FIFO   = 3'b100;
    localparam logic [2:0] GRP_SERIAL = 3'b101;

    // keyboard sub-ports, address bits 1..0
    localparam logic [1:0] SUB_KEY_DATA = 2'd0;
    localparam logic [1:0] SUB_KEY_STAT = 2'd1;
    localparam logic [1:0] SUB_KEY_CMD  = 2'd2;
    localparam logic [1:0] SUB_KEY_DUMMY = 2'd3;

    // byte constants
    localparam logic [7:0] BYTE_IDLE      = 8'hff;
    localparam logic [7:0] BYTE_KEY_STAT  = 8'hf7;
    localparam logic [7:0] BYTE_CMD_SET   = 8'hfb;
    localparam logic [7:0] BYTE_CMD_CLEAR = 8'h00;
    localparam logic [7:0] BYTE_KEY_RESET = 8'ha0;
    localparam logic [7:0] BYTE_FIFO_STAT = 8'h04;

    localparam logic [2:0] BASE_PAGE_RESET = 3'd7;

    // per-channel fifo controls
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } kbp_fifo_ctrl_t;

    // state seen by the decoder
    typedef struct packed {
        logic            key_pending;
        logic [7:0]      key_code;
        logic [1:0]      hold_valid;
        logic [1:0][7:0] hold_byte;
        logic [1:0]      fifo_not_empty;
        logic [1:0][7:0] fifo_data;
    } kbp_state_t;

    // state updates requested by the decoder
    typedef struct packed {
        logic                key_set;
        logic [7:0]          key_value;
        logic                key_clear;
        logic                hold_set;
        logic                hold_clear;
        logic                ch;
        kbp_fifo_ctrl_t [1:0] fifo;
    } kbp_update_t;

    // one result item
    typedef struct packed {
        logic       claimed;
        logic [7:0] read_data;
        logic [1:0] forward_target;
        logic [1:0] forward_register;
    } kbp_result_t;

endpackage

FILE: rtl/keyboard_port_and_loopback_fifos_core.sv
// An accepted access is held in the input register, and its result in the result register.
// Throughput: one access per cycle while the result is not stalled; the single decode stage sets the rate.
// A stalled result register holds the decode stage, which then holds the input.
// Reset (aresetn low, synchronous) empties both stages and both fifos, clears
// key pending and the serial holders, and sets base_page to 7.
// ----------------------------------------------------------------------------
// keyboard_port_and_loopback_fifos_core
// I/O-mapped keyboard card with printer and serial loopback storage.
// ----------------------------------------------------------------------------
module keyboard_port_and_loopback_fifos_core
    import kbp_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_port_address,
    input  logic [7:0] s_write_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_claimed,
    output logic [7:0] m_read_data,
    output logic [1:0] m_forward_target,
    output logic [1:0] m_forward_register
);

    logic [2:0]      base_page_reg;
    logic            in_valid_reg;
    logic [1:0]      in_kind_reg;
    logic [7:0]      in_addr_reg;
    logic [7:0]      in_data_reg;
    logic            out_valid_reg;
    kbp_result_t     out_reg;
    logic            key_pending_reg;
    logic [7:0]      key_code_reg;
    logic [1:0]      hold_valid_reg;
    logic [1:0][7:0] hold_byte_reg;
    logic            advance;
    kbp_state_t      state;
    kbp_update_t     update;
    kbp_result_t     result;
    kbp_fifo_ctrl_t  fifo_ctrl [2];
    logic [1:0]      fifo_not_empty;
    logic [7:0]      fifo_data [2];

    // stage handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_page_reg <= BASE_PAGE_RESET;
        end else if (cfg_we) begin
            base_page_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_addr_reg <= s_port_address;
            in_data_reg <= s_write_data;
        end
    end

    // decode
    assign state.key_pending    = key_pending_reg;
    assign state.key_code       = key_code_reg;
    assign state.hold_valid     = hold_valid_reg;
    assign state.hold_byte      = hold_byte_reg;
    assign state.fifo_not_empty = fifo_not_empty;
    assign state.fifo_data[0]   = fifo_data[0];
    assign state.fifo_data[1]   = fifo_data[1];

    kbp_decode u_decode (
        .kind         (in_kind_reg),
        .port_address (in_addr_reg),
        .write_data   (in_data_reg),
        .base_page    (base_page_reg),
        .state        (state),
        .result       (result),
        .update       (update)
    );

    // keyboard code and pending flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_pending_reg <= 1'b0;
            key_code_reg    <= BYTE_KEY_RESET;
        end else if (advance) begin
            if (update.key_set) begin
                key_pending_reg <= 1'b1;
                key_code_reg    <= update.key_value;
            end else if (update.key_clear) begin
                key_pending_reg <= 1'b0;
            end
        end
    end

    // serial loopback holders
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= '0;
        end else if (advance) begin
            if (update.hold_set) begin
                hold_valid_reg[update.ch] <= 1'b1;
            end else if (update.hold_clear) begin
                hold_valid_reg[update.ch] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && update.hold_set) begin
            hold_byte_reg[update.ch] <= in_data_reg;
        end
    end

    // printer loopback fifos
    for (genvar c = 0; c < 2; c++) begin : g_fifo
        assign fifo_ctrl[c].push  = advance && update.fifo[c].push;
        assign fifo_ctrl[c].pop   = advance && update.fifo[c].pop;
        assign fifo_ctrl[c].clear = advance && update.fifo[c].clear;

        kbp_fifo #(
            .FIFO_DEPTH (FIFO_DEPTH)
        ) u_fifo (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (fifo_ctrl[c]),
            .wdata     (in_data_reg),
            .not_empty (fifo_not_empty[c]),
            .rdata     (fifo_data[c])
        );
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_claimed          = out_reg.claimed;
    assign m_read_data        = out_reg.read_data;
    assign m_forward_target   = out_reg.forward_target;
    assign m_forward_register = out_reg.forward_register;

endmodule

FILE: rtl/kbp_fifo.sv
// ----------------------------------------------------------------------------
// kbp_fifo
// One printer loopback fifo with registered read of the head entry.
// ----------------------------------------------------------------------------
module kbp_fifo
    import kbp_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  kbp_fifo_ctrl_t ctrl,
    input  logic [7:0]     wdata,
    output logic           not_empty,
    output logic [7:0]     rdata
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [7:0]       store_mem [FIFO_DEPTH];
    logic [7:0]       rdata_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = ctrl.push && !full;
    assign do_pop    = ctrl.pop && not_empty;
    assign rdata     = rdata_reg;

    // pointer and count update
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else if (do_push) begin
            tail_next  = ptr_inc(tail_reg);
            count_next = count_reg + 1'b1;
        end else if (do_pop) begin
            head_next  = ptr_inc(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // store write and head prefetch, bypassing a push into the new head slot
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_mem[tail_reg] <= wdata;
        end
        if (do_push && (tail_reg == head_next)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= store_mem[head_next];
        end
    end

endmodule

FILE: rtl/kbp_decode.sv
// ----------------------------------------------------------------------------
// kbp_decode
// Port window decode: builds the result and the state updates for one access.
// ----------------------------------------------------------------------------
module kbp_decode
    import kbp_pkg::*;
(
    input  logic [1:0]  kind,
    input  logic [7:0]  port_address,
    input  logic [7:0]  write_data,
    input  logic [2:0]  base_page,
    input  kbp_state_t  state,
    output kbp_result_t result,
    output kbp_update_t update
);

    logic       is_read;
    logic       ch;
    logic [1:0] sub;
    logic [2:0] grp;

    assign is_read = (kind == KIND_READ);
    assign ch      = port_address[1];
    assign sub     = port_address[1:0];
    assign grp     = port_address[4:2];

    always_comb begin
        result.claimed          = 1'b0;
        result.read_data        = BYTE_IDLE;
        result.forward_target   = TGT_NONE;
        result.forward_register = 2'd0;
        update                  = '0;
        update.key_value        = write_data;
        update.ch               = ch;

        unique case (kind) inside
            KIND_KEY: begin
                update.key_set = 1'b1;
            end
            KIND_READ, KIND_WRITE: begin
                if (port_address[7:5] == base_page) begin
                    unique case (grp) inside
                        // keyboard data, status and command
                        GRP_KEY: begin
                            if (is_read) begin
                                unique case (sub)
                                    SUB_KEY_DATA: begin
                                        result.claimed = 1'b1;
                                        if (state.key_pending) begin
                                            update.key_clear = 1'b1;
                                            result.read_data = state.key_code;
                                        end
                                    end
                                    SUB_KEY_STAT: begin
                                        result.claimed   = 1'b1;
                                        result.read_data = state.key_pending ?
                                                           BYTE_KEY_STAT : BYTE_IDLE;
                                    end
                                    SUB_KEY_DUMMY: result.claimed = 1'b1;
                                    default: ;
                                endcase
                            end else if (sub == SUB_KEY_CMD) begin
                                result.claimed = 1'b1;
                                if (write_data == BYTE_CMD_SET) begin
                                    update.key_set   = 1'b1;
                                    update.key_value = BYTE_KEY_RESET;
                                end else if (write_data == BYTE_CMD_CLEAR) begin
                                    update.key_clear = 1'b1;
                                end
                            end
                        end
                        // printer loopback fifos
                        GRP_FIFO: begin
                            result.claimed = 1'b1;
                            if (!port_address[0]) begin
                                if (is_read) begin
                                    if (state.fifo_not_empty[ch]) begin
                                        update.fifo[ch].pop = 1'b1;
                                        result.read_data    = state.fifo_data[ch];
                                    end
                                end else begin
                                    update.fifo[ch].push = 1'b1;
                                end
                            end else if (is_read) begin
                                result.read_data = BYTE_FIFO_STAT |
                                                   {7'd0, state.fifo_not_empty[ch]};
                            end else begin
                                update.fifo[ch].clear = 1'b1;
                            end
                        end
                        // serial loopback holders
                        GRP_SERIAL: begin
                            result.claimed = 1'b1;
                            if (is_read && !port_address[0] && state.hold_valid[ch]) begin
                                update.hold_clear = 1'b1;
                                result.read_data  = state.hold_byte[ch];
                            end else begin
                                result.forward_target   = TGT_SERIAL;
                                result.forward_register = sub;
                                if (!is_read) begin
                                    update.hold_set   = !port_address[0];
                                    update.hold_clear = port_address[0];
                                end
                            end
                        end
                        // timer chip
                        3'b11?: begin
                            result.claimed          = 1'b1;
                            result.forward_target   = TGT_TIMER;
                            result.forward_register = sub;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/kbp_checker.sv
// ----------------------------------------------------------------------------
// kbp_checker
// Port-level checks on the result channel of the keyboard port core.
// ----------------------------------------------------------------------------
module kbp_checker
    import kbp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_claimed,
    input logic [7:0] m_read_data,
    input logic [1:0] m_forward_target,
    input logic [1:0] m_forward_register
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) &&
        $stable(m_claimed) && $stable(m_forward_target))
        else $error("stalled result changed");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // unclaimed access gives idle byte and no forwarding
    a_unclaimed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_claimed |->
        m_read_data == BYTE_IDLE && m_forward_target == TGT_NONE &&
        m_forward_register == 2'd0)
        else $error("unclaimed result not idle");

    // forwarded access returns the idle byte
    a_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_forward_target != TGT_NONE |->
        m_claimed && m_read_data == BYTE_IDLE)
        else $error("forwarded result carries data");

    // register field only for forwarded transfers
    a_fwd_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_forward_target == TGT_NONE |-> m_forward_register == 2'd0)
        else $error("register field set without forwarding");

endmodule

bind keyboard_port_and_loopback_fifos_core kbp_checker u_kbp_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_claimed          (m_claimed),
    .m_read_data        (m_read_data),
    .m_forward_target   (m_forward_target),
    .m_forward_register (m_forward_register)
);
